// File: rtl/tpcr_pkg.sv
package tpcr_pkg;

    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_POLL    = 2'd2;

    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_UP   = 2'b01;
    localparam logic [1:0] DIR_DOWN = 2'b11;

    localparam logic [1:0] CFG_REPEAT_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_COMMIT_GAP      = 2'd1;
    localparam logic [1:0] CFG_SPAN            = 2'd2;
    localparam logic [1:0] CFG_MAX_TAPS        = 2'd3;

    localparam logic [15:0] RESET_REPEAT_INTERVAL = 16'd200;
    localparam logic [15:0] RESET_COMMIT_GAP      = 16'd800;
    localparam logic [15:0] RESET_SPAN            = 16'd4000;
    localparam logic [3:0]  RESET_MAX_TAPS        = 4'd4;

    typedef struct packed {
        logic [15:0] repeat_interval_ms;
        logic [15:0] commit_gap_ms;
        logic [15:0] span_ms;
        logic [3:0]  max_taps;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic        pad;
        logic [31:0] time_ms;
    } item_t;

    typedef struct packed {
        logic [1:0] volume_step;
        logic [3:0] gesture_taps;
    } result_t;

    // count to report when a tap run closes: nothing below two, capped at max
    function automatic logic [3:0] report_taps(input logic [3:0] n, input logic [3:0] cap);
        logic [3:0] r;
        if (n < 4'd2)
        begin
            r = 4'd0;
        end
        else if (n > cap)
        begin
            r = cap;
        end
        else
        begin
            r = n;
        end
        return r;
    endfunction

    // wrapping difference against a 16-bit limit
    function automatic logic elapsed(input logic [31:0] now, input logic [31:0] since,
                                     input logic [15:0] limit);
        logic [31:0] diff;
        diff = now - since;
        return diff >= {16'd0, limit};
    endfunction

endpackage

// File: rtl/tpcr_ifs.sv
interface tpcr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic        pad;
    logic [31:0] time_ms;

    modport source (output valid, output operation, output pad, output time_ms, input ready);
    modport sink   (input valid, input operation, input pad, input time_ms, output ready);
endinterface

interface tpcr_out_if;
    logic              valid;
    logic              ready;
    logic signed [1:0] volume_step;
    logic [3:0]        gesture_taps;

    modport source (output valid, output volume_step, output gesture_taps, input ready);
    modport sink   (input valid, input volume_step, input gesture_taps, output ready);
endinterface

// File: rtl/two_pad_chord_and_repeat_unit.sv
// Two-pad volume controller: takes press, release and poll beats and gives exactly one result
// beat per input beat. Sustained rate is one item per clock unless the output stalls; an item
// is held in the input register, its result comes from a single pass of compare and subtract
// logic against the tracking state and lands in the output register. A stalled output holds
// one result while the input register still takes one more beat. Unchecked by the block, the
// user must write configuration via cfg_we/cfg_index/cfg_wdata while no item is in flight.
module two_pad_chord_and_repeat_unit
    import tpcr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tpcr_in_if.sink       pads,
    tpcr_out_if.source    result,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_wdata
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_vld_reg, item_vld_next;
    logic    out_vld_reg, out_vld_next;
    result_t out_reg;
    result_t res;
    logic    take;
    logic    fire;

    assign fire       = item_vld_reg && (!out_vld_reg || result.ready);
    assign pads.ready = !item_vld_reg || fire;
    assign take       = pads.valid && pads.ready;

    tpcr_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tpcr_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .item  (item_reg),
        .fire  (fire),
        .res   (res)
    );

    always_comb
    begin
        item_vld_next = item_vld_reg;
        if (take)
        begin
            item_vld_next = 1'b1;
        end
        else if (fire)
        begin
            item_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (fire)
        begin
            out_vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.operation <= pads.operation;
            item_reg.pad       <= pads.pad;
            item_reg.time_ms   <= pads.time_ms;
        end
        if (fire)
        begin
            out_reg <= res;
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.volume_step  = $signed(out_reg.volume_step);
    assign result.gesture_taps = out_reg.gesture_taps;

endmodule

// File: rtl/tpcr_cfg_regs.sv
module tpcr_cfg_regs
    import tpcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REPEAT_INTERVAL: cfg_next.repeat_interval_ms = cfg_wdata;
                CFG_COMMIT_GAP:      cfg_next.commit_gap_ms      = cfg_wdata;
                CFG_SPAN:            cfg_next.span_ms            = cfg_wdata;
                CFG_MAX_TAPS:        cfg_next.max_taps           = cfg_wdata[3:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_interval_ms <= RESET_REPEAT_INTERVAL;
            cfg_reg.commit_gap_ms      <= RESET_COMMIT_GAP;
            cfg_reg.span_ms            <= RESET_SPAN;
            cfg_reg.max_taps           <= RESET_MAX_TAPS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/tpcr_core.sv
module tpcr_core
    import tpcr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    fire,
    output result_t res
);

    logic        up_reg,     up_next;
    logic        down_reg,   down_next;
    logic        chord_reg,  chord_next;
    logic [1:0]  dir_reg,    dir_next;
    logic [3:0]  taps_reg,   taps_next;
    logic [31:0] first_reg,  first_next;
    logic [31:0] last_reg,   last_next;
    logic [31:0] step_reg,   step_next;

    always_comb
    begin
        logic       is_up;
        logic [3:0] taps_a;
        logic [3:0] taps_b;
        logic [3:0] gesture;
        logic [3:0] capped;
        logic [1:0] poll_dir;
        logic [1:0] own_dir;

        up_next    = up_reg;
        down_next  = down_reg;
        chord_next = chord_reg;
        dir_next   = dir_reg;
        taps_next  = taps_reg;
        first_next = first_reg;
        last_next  = last_reg;
        step_next  = step_reg;
        res        = '0;

        is_up    = !item.pad;
        own_dir  = is_up ? DIR_UP : DIR_DOWN;
        taps_a   = taps_reg;
        taps_b   = taps_reg;
        gesture  = 4'd0;
        capped   = 4'd0;
        poll_dir = DIR_NONE;

        unique case (item.operation)
            OP_PRESS:
            begin
                if (is_up)
                begin
                    up_next = 1'b1;
                end
                else
                begin
                    down_next = 1'b1;
                end
                if (up_next && down_next)
                begin
                    chord_next = 1'b1;
                    dir_next   = DIR_NONE;
                end
            end
            OP_RELEASE:
            begin
                if (is_up)
                begin
                    up_next = 1'b0;
                end
                else
                begin
                    down_next = 1'b0;
                end
                if (dir_reg == own_dir)
                begin
                    dir_next = DIR_NONE;
                end
                // chord ends when both pads are up: one tap
                if (chord_reg && !up_next && !down_next)
                begin
                    chord_next = 1'b0;
                    if (taps_reg != 4'd0 && elapsed(item.time_ms, first_reg, cfg.span_ms))
                    begin
                        gesture = report_taps(taps_reg, cfg.max_taps);
                        taps_a  = 4'd0;
                    end
                    first_next = (taps_a == 4'd0) ? item.time_ms : first_reg;
                    taps_b     = taps_a + 4'd1;
                    taps_next  = taps_b;
                    last_next  = item.time_ms;
                    if (taps_b >= cfg.max_taps)
                    begin
                        taps_next  = 4'd0;
                        first_next = 32'd0;
                        last_next  = 32'd0;
                        capped     = report_taps(taps_b, cfg.max_taps);
                        if (capped != 4'd0)
                        begin
                            gesture = capped;
                        end
                    end
                    res.gesture_taps = gesture;
                end
            end
            OP_POLL:
            begin
                if (taps_reg != 4'd0 && !up_reg && !down_reg && !chord_reg
                    && elapsed(item.time_ms, last_reg, cfg.commit_gap_ms))
                begin
                    res.gesture_taps = report_taps(taps_reg, cfg.max_taps);
                    taps_a     = 4'd0;
                    taps_next  = 4'd0;
                    first_next = 32'd0;
                    last_next  = 32'd0;
                end
                if (chord_reg || (up_reg && down_reg) || taps_a != 4'd0)
                begin
                    dir_next = DIR_NONE;
                end
                else
                begin
                    if (up_reg && !down_reg)
                    begin
                        poll_dir = DIR_UP;
                    end
                    else if (down_reg && !up_reg)
                    begin
                        poll_dir = DIR_DOWN;
                    end
                    if (poll_dir == DIR_NONE)
                    begin
                        dir_next = DIR_NONE;
                    end
                    else if (dir_reg != poll_dir)
                    begin
                        // first step fires at once
                        dir_next        = poll_dir;
                        step_next       = item.time_ms;
                        res.volume_step = poll_dir;
                    end
                    else if (elapsed(item.time_ms, step_reg, cfg.repeat_interval_ms))
                    begin
                        step_next       = item.time_ms;
                        res.volume_step = poll_dir;
                    end
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg    <= 1'b0;
            down_reg  <= 1'b0;
            chord_reg <= 1'b0;
            dir_reg   <= DIR_NONE;
            taps_reg  <= 4'd0;
            first_reg <= 32'd0;
            last_reg  <= 32'd0;
            step_reg  <= 32'd0;
        end
        else if (fire)
        begin
            up_reg    <= up_next;
            down_reg  <= down_next;
            chord_reg <= chord_next;
            dir_reg   <= dir_next;
            taps_reg  <= taps_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: rtl/tpcr_checker.sv
module tpcr_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic signed [1:0] volume_step,
    input logic [3:0]        gesture_taps
);

    // input side only backs up behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a stalled result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (volume_step != 2'sb10))
        else $error("volume step out of range");

    // a gesture commit needs both pads up, so no step in the same beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !((volume_step != 2'sb00) && (gesture_taps != 4'd0)))
        else $error("step and gesture in one beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(volume_step)
                                       && $stable(gesture_taps)))
        else $error("stalled result changed");

endmodule

bind two_pad_chord_and_repeat_unit tpcr_checker u_tpcr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (pads.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .volume_step  (result.volume_step),
    .gesture_taps (result.gesture_taps)
);

// File: tb/sv/tb_two_pad_chord_and_repeat_unit.sv
`timescale 1ns / 1ps

module tb_two_pad_chord_and_repeat_unit;
    import tpcr_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    // tracks pad state and tap runs, holds the outcomes still owed by the block
    class gesture_scoreboard;
        logic [15:0] ivl;
        logic [15:0] gap;
        logic [15:0] span;
        logic [3:0]  cap;
        logic        up_on;
        logic        dn_on;
        logic        chord_on;
        logic [1:0]  dir;
        logic [3:0]  taps;
        logic [31:0] t_first;
        logic [31:0] t_last;
        logic [31:0] t_step;
        result_t     pending_outcomes[$];
        int          errors;
        int          n_events;
        int          n_outcomes;
        int          n_steps;
        int          n_gestures;

        function new();
            ivl = RESET_REPEAT_INTERVAL;
            gap = RESET_COMMIT_GAP;
            span = RESET_SPAN;
            cap = RESET_MAX_TAPS;
            up_on = 1'b0;
            dn_on = 1'b0;
            chord_on = 1'b0;
            dir = DIR_NONE;
            taps = 4'd0;
            t_first = 32'd0;
            t_last = 32'd0;
            t_step = 32'd0;
            errors = 0;
            n_events = 0;
            n_outcomes = 0;
            n_steps = 0;
            n_gestures = 0;
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [15:0] val);
            case (idx)
                CFG_REPEAT_INTERVAL: ivl = val;
                CFG_COMMIT_GAP:      gap = val;
                CFG_SPAN:            span = val;
                CFG_MAX_TAPS:        cap = val[3:0];
            endcase
        endfunction

        function logic [3:0] close_run();
            logic [3:0] n;
            n = taps;
            taps = 4'd0;
            t_first = 32'd0;
            t_last = 32'd0;
            if (n < 4'd2)
            begin
                return 4'd0;
            end
            if (n > cap)
            begin
                n = cap;
            end
            return n;
        endfunction

        function logic [3:0] end_chord(input logic [31:0] now);
            logic [3:0]  g;
            logic [3:0]  g2;
            logic [31:0] since_first;
            g = 4'd0;
            since_first = now - t_first;
            if (taps != 4'd0 && since_first >= {16'd0, span})
            begin
                g = close_run();
            end
            if (taps == 4'd0)
            begin
                t_first = now;
            end
            taps = taps + 4'd1;
            t_last = now;
            if (taps >= cap)
            begin
                g2 = close_run();
                if (g2 != 4'd0)
                begin
                    g = g2;
                end
            end
            return g;
        endfunction

        function void note_event(input logic [1:0] op, input logic pad, input logic [31:0] now);
            result_t     r;
            logic [1:0]  want;
            logic [31:0] quiet;
            logic [31:0] since_step;
            r.volume_step = DIR_NONE;
            r.gesture_taps = 4'd0;
            case (op)
                OP_PRESS:
                begin
                    if (pad == 1'b0)
                    begin
                        up_on = 1'b1;
                    end
                    else
                    begin
                        dn_on = 1'b1;
                    end
                    if (up_on && dn_on)
                    begin
                        chord_on = 1'b1;
                        dir = DIR_NONE;
                    end
                end
                OP_RELEASE:
                begin
                    if (pad == 1'b0)
                    begin
                        up_on = 1'b0;
                    end
                    else
                    begin
                        dn_on = 1'b0;
                    end
                    if (dir == ((pad == 1'b0) ? DIR_UP : DIR_DOWN))
                    begin
                        dir = DIR_NONE;
                    end
                    if (chord_on && !up_on && !dn_on)
                    begin
                        chord_on = 1'b0;
                        r.gesture_taps = end_chord(now);
                    end
                end
                OP_POLL:
                begin
                    quiet = now - t_last;
                    if (taps != 4'd0 && !up_on && !dn_on && !chord_on && quiet >= {16'd0, gap})
                    begin
                        r.gesture_taps = close_run();
                    end
                    if (chord_on || (up_on && dn_on) || taps != 4'd0)
                    begin
                        dir = DIR_NONE;
                    end
                    else
                    begin
                        want = DIR_NONE;
                        if (up_on && !dn_on)
                        begin
                            want = DIR_UP;
                        end
                        else if (dn_on && !up_on)
                        begin
                            want = DIR_DOWN;
                        end
                        since_step = now - t_step;
                        if (want == DIR_NONE)
                        begin
                            dir = DIR_NONE;
                        end
                        else if (dir != want)
                        begin
                            dir = want;
                            t_step = now;
                            r.volume_step = want;
                        end
                        else if (since_step >= {16'd0, ivl})
                        begin
                            t_step = now;
                            r.volume_step = want;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            n_events++;
            pending_outcomes.push_back(r);
        endfunction

        function void check_result(input logic [1:0] vs, input logic [3:0] gt);
            result_t want;
            if (pending_outcomes.size() == 0)
            begin
                $error("result beat with nothing pending: volume_step %0d gesture_taps %0d",
                       $signed(vs), gt);
                errors++;
                return;
            end
            want = pending_outcomes.pop_front();
            n_outcomes++;
            if (vs !== want.volume_step)
            begin
                $error("volume_step expected %0d got %0d", $signed(want.volume_step), $signed(vs));
                errors++;
            end
            if (gt !== want.gesture_taps)
            begin
                $error("gesture_taps expected %0d got %0d", want.gesture_taps, gt);
                errors++;
            end
            if (want.volume_step != DIR_NONE)
            begin
                n_steps++;
            end
            if (want.gesture_taps != 4'd0)
            begin
                n_gestures++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    tpcr_in_if  pads_if();
    tpcr_out_if res_if();

    two_pad_chord_and_repeat_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pads      (pads_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    gesture_scoreboard sb = new();

    bit          no_idle;
    int          n_sent;
    int          n_settings;
    logic [31:0] now_ms;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_if.ready <= no_idle || ($urandom_range(99) >= 35);
        end
    end

    always @(posedge clk)
    begin
        if (pads_if.valid && pads_if.ready)
        begin
            sb.note_event(pads_if.operation, pads_if.pad, pads_if.time_ms);
        end
        if (res_if.valid && res_if.ready)
        begin
            sb.check_result(res_if.volume_step, res_if.gesture_taps);
        end
    end

    task automatic send(input logic [1:0] op, input logic pad, input logic [31:0] t);
        pads_if.valid <= 1'b1;
        pads_if.operation <= op;
        pads_if.pad <= pad;
        pads_if.time_ms <= t;
        @(posedge clk);
        while (!pads_if.ready)
        begin
            @(posedge clk);
        end
        n_sent++;
        if (!no_idle && $urandom_range(99) < 35)
        begin
            pads_if.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic load_regs(input logic [15:0] ivl, input logic [15:0] gap,
                             input logic [15:0] span, input logic [3:0] cap);
        put_reg(CFG_REPEAT_INTERVAL, ivl);
        put_reg(CFG_COMMIT_GAP, gap);
        put_reg(CFG_SPAN, span);
        // upper bits of the write are don't-care for the 4-bit register
        put_reg(CFG_MAX_TAPS, {12'($urandom), cap});
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic settle();
        pads_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // both pads down then both up, in random order
    task automatic chord_tap(input int dt);
        logic p;
        p = 1'($urandom_range(1));
        now_ms += dt;
        send(OP_PRESS, p, now_ms);
        now_ms += $urandom_range(40);
        send(OP_PRESS, ~p, now_ms);
        if ($urandom_range(3) == 0)
        begin
            send(OP_POLL, ~p, now_ms);
        end
        p = 1'($urandom_range(1));
        now_ms += $urandom_range(120);
        send(OP_RELEASE, p, now_ms);
        now_ms += $urandom_range(40);
        send(OP_RELEASE, ~p, now_ms);
    endtask

    task automatic gesture_run();
        int dt;
        repeat ($urandom_range(int'(sb.cap) + 1, 1))
        begin
            if ($urandom_range(7) == 0)
            begin
                dt = $urandom_range(2 * int'(sb.span) + 1);
            end
            else
            begin
                dt = $urandom_range(int'(sb.gap) / 2);
            end
            chord_tap(dt);
            if ($urandom_range(4) == 0)
            begin
                send(OP_POLL, 1'($urandom_range(1)), now_ms + $urandom_range(int'(sb.gap)));
            end
        end
        repeat ($urandom_range(3, 1))
        begin
            now_ms += $urandom_range(2 * int'(sb.gap) + 1);
            send(OP_POLL, 1'($urandom_range(1)), now_ms);
        end
    endtask

    task automatic hold_run();
        logic p;
        p = 1'($urandom_range(1));
        now_ms += $urandom_range(2 * int'(sb.gap) + 1);
        send(OP_PRESS, p, now_ms);
        repeat ($urandom_range(6, 1))
        begin
            now_ms += $urandom_range(2 * int'(sb.ivl) + 2);
            send(OP_POLL, 1'($urandom_range(1)), now_ms);
        end
        now_ms += $urandom_range(50);
        send(OP_RELEASE, p, now_ms);
        if ($urandom_range(1) == 0)
        begin
            send(OP_POLL, 1'($urandom_range(1)), now_ms);
        end
    endtask

    task automatic noise_burst();
        logic [31:0] t;
        repeat ($urandom_range(4, 1))
        begin
            if ($urandom_range(3) == 0)
            begin
                t = $urandom;
            end
            else
            begin
                t = now_ms + $urandom_range(500);
            end
            send(2'($urandom_range(3)), 1'($urandom_range(1)), t);
        end
    endtask

    task automatic play_sequence();
        int kind;
        kind = $urandom_range(9);
        if ($urandom_range(19) == 0)
        begin
            // jump the clock, sometimes just short of the 32-bit wrap
            if ($urandom_range(1) == 0)
            begin
                now_ms = $urandom;
            end
            else
            begin
                now_ms = 32'hFFFF_FFFF - $urandom_range(5000);
            end
        end
        if (kind < 4)
        begin
            gesture_run();
        end
        else if (kind < 7)
        begin
            hold_run();
        end
        else
        begin
            noise_burst();
        end
    endtask

    initial
    begin
        int target;
        no_idle = 1'b0;
        n_sent = 0;
        n_settings = 0;
        now_ms = 32'd0;
        rst_n <= 1'b0;
        pads_if.valid <= 1'b0;
        pads_if.operation <= OP_POLL;
        pads_if.pad <= 1'b0;
        pads_if.time_ms <= 32'd0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_REPEAT_INTERVAL;
        cfg_wdata <= 16'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: nothing held, unused op, single pad repeat, wrap
        send(OP_POLL, 1'b1, 32'd0);
        send(OP_UNUSED, 1'b1, 32'hFFFF_FFFF);
        send(OP_PRESS, 1'b0, 32'd10);
        send(OP_POLL, 1'b0, 32'd10);
        send(OP_POLL, 1'b1, 32'd100);
        send(OP_PRESS, 1'b0, 32'd150);
        send(OP_POLL, 1'b0, 32'd210);
        send(OP_RELEASE, 1'b0, 32'd230);
        send(OP_RELEASE, 1'b0, 32'd240);
        send(OP_PRESS, 1'b1, 32'hFFFF_FF00);
        send(OP_POLL, 1'b0, 32'hFFFF_FF00);
        send(OP_POLL, 1'b1, 32'h0000_0010);
        send(OP_RELEASE, 1'b1, 32'h0000_0020);
        // lone chord closes below two taps
        now_ms = 32'h0000_0100;
        chord_tap(0);
        send(OP_POLL, 1'b0, now_ms + 32'd900);
        // three taps left pending, then the cap drops under them
        now_ms += 32'd1000;
        chord_tap(100);
        chord_tap(100);
        chord_tap(100);
        settle();

        // zero interval, gap and span, cap of one
        load_regs(16'd0, 16'd0, 16'd0, 4'd1);
        send(OP_POLL, 1'b1, now_ms);
        send(OP_PRESS, 1'b1, now_ms);
        send(OP_POLL, 1'b0, now_ms);
        send(OP_POLL, 1'b0, now_ms);
        send(OP_RELEASE, 1'b1, now_ms);
        chord_tap(0);
        send(OP_POLL, 1'b0, now_ms);
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: load_regs(16'd1, 16'd1, 16'd1, 4'd2);
                1: load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
                5: load_regs(RESET_REPEAT_INTERVAL, RESET_COMMIT_GAP, RESET_SPAN,
                             RESET_MAX_TAPS);
                default: load_regs(16'($urandom_range(1000, 1)), 16'($urandom_range(3000, 1)),
                                   16'($urandom_range(12000, 1)), 4'($urandom_range(15, 2)));
            endcase
            no_idle = (ph == 3);
            target = n_sent + 125;
            while (n_sent < target)
            begin
                play_sequence();
            end
            settle();
        end

        $display("sent %0d pad beats under %0d register settings, checked %0d results",
                 sb.n_events, n_settings, sb.n_outcomes);
        $display("saw %0d volume steps and %0d chord gestures, %0d mismatches",
                 sb.n_steps, sb.n_gestures, sb.errors);
        if (sb.errors == 0 && sb.pending_outcomes.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/tpcr_pkg.sv
rtl/tpcr_ifs.sv
rtl/tpcr_cfg_regs.sv
rtl/tpcr_core.sv
rtl/two_pad_chord_and_repeat_unit.sv
rtl/tpcr_checker.sv
tb/sv/tb_two_pad_chord_and_repeat_unit.sv
